/* src/scbrb_pkg.sv */
package scbrb_pkg;

    // Fixed field widths
    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 9;
    localparam int STAT_W = 2;

    // Largest value that the count fields can carry
    localparam int CNT_MAX = (2 ** CNT_W) - 1;

    // Default ring depth
    localparam int DEPTH_DEF = 256;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMMIT = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NO_COMMIT = 2'd3;

    // Register port widths
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    // Outcome of one transaction, handed from the control unit to the top
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              rd_ok;
        logic [CNT_W-1:0]  count;
    } t_result;

endpackage

/* src/staged_commit_byte_ring_buffer.sv */
// Staged-commit byte ring buffer.
// Commands arrive on the slave stream: s_tuser carries the command (put, get
// or commit) and s_tdata the byte to store on a put. Each input transaction
// produces exactly one result transaction on the master stream: m_tuser
// carries the status, m_tdata the byte read by a successful get (zero
// otherwise) together with the committed byte count after the command.
// Puts and gets only move working pointers and pending counters; a commit
// publishes pending puts (or, if there are none, pending gets) to the
// committed pointers and count, discards the other kind and reloads the
// working pointers.
// The APB port holds one register, size_in_use, the number of ring entries
// in use; it should be written only while the block is idle.
// Each result is registered as its input is taken, and one transaction is
// taken every cycle unless the receiver stalls: all pointer and count
// updates are single increments and compares; the store has one registered read port.
// When the receiver stalls the result is held in the output register and
// the input is held off until that result is taken.
// Reset empties the buffer and sets size_in_use to the full depth; the byte
// store itself is not cleared, so a get of an entry never written reads undefined data.
module staged_commit_byte_ring_buffer
    import scbrb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] write_byte
    input  logic [1:0]            s_tuser,   // [1:0] cmd
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // [7:0] read_data, [16:8] committed_bytes
    output logic [1:0]            m_tuser,   // [1:0] status
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int PW = $clog2(DEPTH);

    logic [CNT_W-1:0]  r_size;
    logic [CNT_W-1:0]  r_eff;
    logic [CNT_W-1:0]  n_eff;
    logic              r_valid;
    t_result           r_res;

    logic              w_accept;
    logic              w_cfg_wr;
    t_result           w_result;
    logic              w_mem_we;
    logic [PW-1:0]     w_mem_waddr;
    logic              w_mem_re;
    logic [PW-1:0]     w_mem_raddr;
    logic [BYTE_W-1:0] w_rdata;

    // Configuration. There is a single register, so the whole (word) address
    // decodes to it. The effective size is worked out once at write time:
    // zero acts as one and anything above the depth acts as the depth.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = {{(APB_DATA_W-CNT_W){1'b0}}, r_size} | APB_DATA_W'(paddr & '0);

    always_comb begin
        if (pwdata[CNT_W-1:0] == '0) begin
            n_eff = CNT_W'(1);
        end else if (32'(pwdata[CNT_W-1:0]) > 32'(DEPTH)) begin
            n_eff = CNT_W'(DEPTH);
        end else begin
            n_eff = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= CNT_W'(DEPTH);
            r_eff  <= (DEPTH > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(DEPTH);
        end else if (w_cfg_wr) begin
            r_size <= pwdata[CNT_W-1:0];
            r_eff  <= n_eff;
        end
    end

    // A new transaction is taken whenever the output register is free or is
    // being emptied in the same cycle.
    assign s_tready = !r_valid || m_tready;
    assign w_accept = s_tvalid && s_tready;

    scbrb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_eff_size  (r_eff),
        .i_accept    (w_accept),
        .i_cmd       (s_tuser),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_re    (w_mem_re),
        .o_mem_raddr (w_mem_raddr),
        .o_result    (w_result)
    );

    scbrb_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (s_tdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_rdata)
    );

    // Output register. The read byte sits in the memory's read register,
    // which only changes on a successful get, so it holds across a stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= w_result;
        end
    end

    assign m_tvalid = r_valid;
    assign m_tuser  = r_res.status;
    assign m_tdata  = {7'd0, r_res.count, (r_res.rd_ok ? w_rdata : BYTE_W'(0))};

endmodule

/* src/scbrb_mem.sv */
module scbrb_mem
    import scbrb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [BYTE_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [BYTE_W-1:0]        o_rdata
);

    logic [BYTE_W-1:0] r_store [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_store[i_waddr] <= i_wdata;
        end
    end

    // Read data is held until the next read so that a stalled result stays put.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_store[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/scbrb_ctrl.sv */
module scbrb_ctrl
    import scbrb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [CNT_W-1:0]         i_eff_size,
    input  logic                     i_accept,
    input  logic [CMD_W-1:0]         i_cmd,
    output logic                     o_mem_we,
    output logic [$clog2(DEPTH)-1:0] o_mem_waddr,
    output logic                     o_mem_re,
    output logic [$clog2(DEPTH)-1:0] o_mem_raddr,
    output t_result                  o_result
);

    localparam int PW    = $clog2(DEPTH);
    localparam int CLAMP = (DEPTH > CNT_MAX) ? CNT_MAX : DEPTH;

    logic [PW-1:0]    r_cwp, n_cwp;
    logic [PW-1:0]    r_crp, n_crp;
    logic [PW-1:0]    r_wwp, n_wwp;
    logic [PW-1:0]    r_wrp, n_wrp;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_pp, n_pp;
    logic [CNT_W-1:0] r_pg, n_pg;

    logic [CNT_W:0]   w_sum;
    logic             w_put_ok;
    logic             w_get_ok;

    // Step a pointer, wrapping to zero once it reaches the size in use.
    function automatic logic [PW-1:0] f_adv(input logic [PW-1:0] p,
                                            input logic [CNT_W-1:0] eff);
        logic [PW:0] nx;
        nx = {1'b0, p} + (PW+1)'(1);
        if (32'(nx) >= 32'(eff)) begin
            return '0;
        end
        return nx[PW-1:0];
    endfunction

    assign w_sum    = {1'b0, r_count} + {1'b0, r_pp};
    assign w_put_ok = (w_sum < {1'b0, i_eff_size});
    assign w_get_ok = (r_pg < r_count);

    always_comb begin
        n_cwp   = r_cwp;
        n_crp   = r_crp;
        n_wwp   = r_wwp;
        n_wrp   = r_wrp;
        n_count = r_count;
        n_pp    = r_pp;
        n_pg    = r_pg;
        o_result.status = ST_OK;
        o_result.rd_ok  = 1'b0;
        case (i_cmd)
            CMD_PUT: begin
                if (w_put_ok) begin
                    n_wwp = f_adv(r_wwp, i_eff_size);
                    n_pp  = r_pp + CNT_W'(1);
                end else begin
                    o_result.status = ST_FULL;
                end
            end
            CMD_GET: begin
                if (w_get_ok) begin
                    n_wrp = f_adv(r_wrp, i_eff_size);
                    n_pg  = r_pg + CNT_W'(1);
                    o_result.rd_ok = 1'b1;
                end else begin
                    o_result.status = ST_EMPTY;
                end
            end
            CMD_COMMIT: begin
                if (r_pp != '0) begin
                    // Staged puts take precedence; staged gets are dropped.
                    if (w_sum > (CNT_W+1)'(CLAMP)) begin
                        n_count = CNT_W'(CLAMP);
                    end else begin
                        n_count = w_sum[CNT_W-1:0];
                    end
                    n_cwp = r_wwp;
                end else if (r_pg != '0) begin
                    n_count = (r_pg <= r_count) ? (r_count - r_pg) : '0;
                    n_crp   = r_wrp;
                end else begin
                    o_result.status = ST_NO_COMMIT;
                end
                n_pp  = '0;
                n_pg  = '0;
                n_wwp = n_cwp;
                n_wrp = n_crp;
            end
            default: begin
            end
        endcase
        o_result.count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cwp   <= '0;
            r_crp   <= '0;
            r_wwp   <= '0;
            r_wrp   <= '0;
            r_count <= '0;
            r_pp    <= '0;
            r_pg    <= '0;
        end else if (i_accept) begin
            r_cwp   <= n_cwp;
            r_crp   <= n_crp;
            r_wwp   <= n_wwp;
            r_wrp   <= n_wrp;
            r_count <= n_count;
            r_pp    <= n_pp;
            r_pg    <= n_pg;
        end
    end

    assign o_mem_we    = i_accept && (i_cmd == CMD_PUT) && w_put_ok;
    assign o_mem_waddr = r_wwp;
    assign o_mem_re    = i_accept && (i_cmd == CMD_GET) && w_get_ok;
    assign o_mem_raddr = r_wrp;

endmodule

/* tb/sv/staged_ring_tb_pkg.sv */
package staged_ring_tb_pkg;

    import scbrb_pkg::*;

    // The fourth command code has no function in the block.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Byte address of the size_in_use register.
    localparam logic [APB_ADDR_W-1:0] RING_SIZE_ADDR = '0;

    localparam int RING_DEPTH    = DEPTH_DEF;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BYTE_W-1:0] read_byte;
        logic [CNT_W-1:0]  count;
    } ring_reply_t;

    // Mirrors the ring state and holds the replies that are still to come.
    class staged_ring_ledger;
        logic [BYTE_W-1:0] store [RING_DEPTH];
        bit                written [RING_DEPTH];
        int                size_reg;
        int                commit_wp;
        int                commit_rp;
        int                work_wp;
        int                work_rp;
        int                committed_count;
        int                pending_puts;
        int                pending_gets;
        int                failures;
        ring_reply_t       replies_due[$];

        function new();
            size_reg        = RING_DEPTH;
            commit_wp       = 0;
            commit_rp       = 0;
            work_wp         = 0;
            work_rp         = 0;
            committed_count = 0;
            pending_puts    = 0;
            pending_gets    = 0;
            failures        = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function void set_size(logic [CNT_W-1:0] value);
            size_reg = int'(value);
        endfunction

        function int active_size();
            if (size_reg == 0) return 1;
            if (size_reg > RING_DEPTH) return RING_DEPTH;
            return size_reg;
        endfunction

        function int step_ptr(int ptr);
            return (ptr + 1 >= active_size()) ? 0 : ptr + 1;
        endfunction

        // A get that would succeed on an entry never written has no defined
        // result, so the stimulus keeps clear of it.
        function bit get_hits_unwritten();
            return (pending_gets < committed_count) && !written[work_rp];
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= REPORT_LIMIT) $display("%s", msg);
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] wbyte);
            ring_reply_t r;
            r.status    = ST_OK;
            r.read_byte = '0;
            case (cmd)
                CMD_PUT: begin
                    if (committed_count + pending_puts < active_size()) begin
                        store[work_wp]   = wbyte;
                        written[work_wp] = 1'b1;
                        work_wp          = step_ptr(work_wp);
                        pending_puts++;
                    end else begin
                        r.status = ST_FULL;
                    end
                end
                CMD_GET: begin
                    if (pending_gets < committed_count) begin
                        r.read_byte = store[work_rp];
                        work_rp     = step_ptr(work_rp);
                        pending_gets++;
                    end else begin
                        r.status = ST_EMPTY;
                    end
                end
                CMD_COMMIT: begin
                    // Staged puts take priority; staged gets are then lost.
                    if (pending_puts > 0) begin
                        committed_count += pending_puts;
                        if (committed_count > RING_DEPTH) committed_count = RING_DEPTH;
                        commit_wp = work_wp;
                    end else if (pending_gets > 0) begin
                        committed_count = (pending_gets <= committed_count) ?
                                          committed_count - pending_gets : 0;
                        commit_rp = work_rp;
                    end else begin
                        r.status = ST_NO_COMMIT;
                    end
                    pending_puts = 0;
                    pending_gets = 0;
                    work_wp      = commit_wp;
                    work_rp      = commit_rp;
                end
                default: begin
                end
            endcase
            r.count = committed_count[CNT_W-1:0];
            replies_due.push_back(r);
        endfunction

        function void check_result(logic [STAT_W-1:0] status, logic [BYTE_W-1:0] rbyte,
                                   logic [CNT_W-1:0] count);
            ring_reply_t want;
            if (replies_due.size() == 0) begin
                flag($sformatf("unexpected result: status %0d byte %02h count %0d",
                               status, rbyte, count));
                return;
            end
            want = replies_due.pop_front();
            if (status !== want.status)
                flag($sformatf("status mismatch: expected %0d, got %0d", want.status, status));
            if (rbyte !== want.read_byte)
                flag($sformatf("read byte mismatch: expected %02h, got %02h",
                               want.read_byte, rbyte));
            if (count !== want.count)
                flag($sformatf("committed count mismatch: expected %0d, got %0d",
                               want.count, count));
        endfunction
    endclass

endpackage

/* tb/sv/testbench.sv */
module testbench;

    import scbrb_pkg::*;
    import staged_ring_tb_pkg::*;

    // Cycles without any accepted transaction before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 47;
    localparam int PHASE_COUNT    = 9;

    // Idling modes: none, sender idles, receiver stalls, both now and then.
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [7:0] write_byte
    logic [1:0]            s_tuser;   // [1:0] cmd
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;   // [7:0] read_data, [16:8] committed_bytes
    logic [1:0]            m_tuser;   // [1:0] status
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    staged_ring_ledger ledger;
    idle_mode_t        idle_mode;
    int                items_sent;
    int                quiet_cycles;

    staged_commit_byte_ring_buffer i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic bit roll_percent(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic int sender_idle_pct();
        case (idle_mode)
            IDLE_SENDER: return 84;
            IDLE_BOTH:   return 12;
            default:     return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (idle_mode)
            IDLE_RECEIVER: return 84;
            IDLE_BOTH:     return 12;
            default:       return 0;
        endcase
    endfunction

    // The receiver side decides afresh at every edge whether to stall, so
    // stalls land on every phase of the block's work.
    always @(posedge i_clk) begin
        m_tready <= !roll_percent(receiver_stall_pct());
    end

    // Every result transaction is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            ledger.check_result(m_tuser, m_tdata[7:0], m_tdata[16:8]);
        end
    end

    // The watchdog is cleared by any accepted transaction on either stream or
    // on the register port, and by reset.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one command and holds it until the block takes it. The
    // prediction is updated straight after acceptance, so the next choice of
    // command already sees the new ring state. A get that would land on a
    // byte never written is simply not sent.
    task automatic send_command(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] wbyte);
        if (cmd == CMD_GET && ledger.get_hits_unwritten()) return;
        while (roll_percent(sender_idle_pct())) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= wbyte;
        do @(posedge i_clk); while (!s_tready);
        ledger.note_command(cmd, wbyte);
        items_sent++;
    endtask

    // Holds the sender back until every predicted result has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (ledger.replies_due.size() != 0) @(posedge i_clk);
    endtask

    // Register write: a setup cycle, then an access cycle held until pready.
    task automatic write_ring_size(logic [CNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RING_SIZE_ADDR;
        pwdata  <= {(APB_DATA_W - CNT_W)'($urandom()), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ledger.set_size(value);
    endtask

    // One random burst. Most bursts are a run of puts or gets closed by a
    // commit, which is what moves the committed pointers; the rest mix both
    // kinds before the commit or are a single arbitrary command.
    task automatic random_burst();
        int kind;
        int len;
        kind = $urandom_range(99);
        len  = ($urandom_range(15) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
        if (kind < 40) begin
            repeat (len) send_command(CMD_PUT, 8'($urandom()));
            send_command(CMD_COMMIT, 8'($urandom()));
        end else if (kind < 72) begin
            repeat (len) send_command(CMD_GET, 8'($urandom()));
            send_command(CMD_COMMIT, 8'($urandom()));
        end else if (kind < 90) begin
            repeat (len) send_command($urandom_range(1) ? CMD_PUT : CMD_GET, 8'($urandom()));
            send_command(CMD_COMMIT, 8'($urandom()));
        end else begin
            send_command(CMD_W'($urandom_range(3)), 8'($urandom()));
        end
    endtask

    function automatic logic [CNT_W-1:0] phase_size(int phase);
        case (phase)
            0:       return 9'd3;      // below the count left by the directed part
            1:       return 9'd0;      // acts as a one-byte ring
            2:       return 9'd1;
            3:       return 9'd2;
            4:       return 9'd256;
            5:       return 9'd511;    // above the depth, acts as the full ring
            6:       return 9'($urandom_range(4, 255));
            7:       return 9'd300;
            default: return 9'd256;
        endcase
    endfunction

    initial begin
        ledger     = new();
        idle_mode  = IDLE_NONE;
        items_sent = 0;
        i_rst_n    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = CMD_PUT;
        m_tready   = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = RING_SIZE_ADDR;
        pwdata     = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset size: empty get, commit with nothing
        // staged, the unused command, both byte extremes, a get before any
        // commit, a commit with puts and gets both staged (the puts win and
        // the gets are thrown away), and a commit of gets alone.
        send_command(CMD_GET, 8'h00);
        send_command(CMD_COMMIT, 8'h00);
        send_command(CMD_UNUSED, 8'hFF);
        send_command(CMD_PUT, 8'h00);
        send_command(CMD_PUT, 8'hFF);
        send_command(CMD_PUT, 8'hA5);
        send_command(CMD_PUT, 8'h5A);
        send_command(CMD_PUT, 8'h01);
        send_command(CMD_GET, 8'h00);
        send_command(CMD_COMMIT, 8'h00);
        send_command(CMD_GET, 8'h00);
        send_command(CMD_GET, 8'h00);
        send_command(CMD_PUT, 8'h80);
        send_command(CMD_COMMIT, 8'h00);
        send_command(CMD_GET, 8'h00);
        send_command(CMD_COMMIT, 8'h00);
        send_command(CMD_UNUSED, 8'h7F);
        send_command(CMD_GET, 8'h00);
        send_command(CMD_GET, 8'h00);
        send_command(CMD_COMMIT, 8'h00);
        send_command(CMD_PUT, 8'h12);
        send_command(CMD_PUT, 8'h34);
        send_command(CMD_PUT, 8'hFE);
        send_command(CMD_COMMIT, 8'h00);

        // Random phases. The ring size changes only once every result is in,
        // and the idling mode rotates so each size sees different pressure.
        // The first shrink leaves the committed count above the new size, so puts in
        // that phase report full until committed gets bring the count below it.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            int target;
            drain_results();
            write_ring_size(phase_size(phase));
            idle_mode = idle_mode_t'((phase + 1) % 4);
            target    = items_sent + PHASE_ITEMS;
            while (items_sent < target - PHASE_ITEMS / 2) random_burst();
            drain_results();
            while (items_sent < target) random_burst();
        end

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (ledger.replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (ledger.replies_due.size() != 0) begin
            ledger.flag($sformatf("%0d results never arrived", ledger.replies_due.size()));
        end
        if (ledger.failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
